// ===== hw/rtl/text_console_writer_unit_macros.svh =====
// ----------------------------------------------------------------------------
// text_console_writer_unit_macros.svh
// Assertion macros shared by the console writer RTL.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_UNIT_MACROS_SVH
`define TEXT_CONSOLE_WRITER_UNIT_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low
`define TCW_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on i_clk, off while i_rst_n is low
`define TCW_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Types and fixed constants of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // Field widths of the stream items
    localparam int CMD_W      = 2;
    localparam int CHAR_W     = 8;
    localparam int ADDR_W     = 11;
    localparam int POS_W      = 11;
    localparam int OROW_W     = 5;
    localparam int OCOL_W     = 7;
    localparam int COLOR_W    = 4;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 40;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR = 1'd1;
    localparam logic [COLOR_W-1:0]   FG_RESET     = 4'd7;
    localparam logic [COLOR_W-1:0]   BG_RESET     = 4'd0;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // Special characters
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;

    // One display cell
    typedef struct packed {
        logic [COLOR_W-1:0] bg;
        logic [COLOR_W-1:0] fg;
        logic [CHAR_W-1:0]  ch;
    } t_cell;

    localparam int CELL_W = $bits(t_cell);

    // Sequencer states
    typedef enum logic [9:0] {
        S_INIT    = 10'b00_0000_0001,
        S_IDLE    = 10'b00_0000_0010,
        S_SCR_RD  = 10'b00_0000_0100,
        S_SCR_WR  = 10'b00_0000_1000,
        S_FILL    = 10'b00_0001_0000,
        S_PUT     = 10'b00_0010_0000,
        S_CLR     = 10'b00_0100_0000,
        S_RD_REQ  = 10'b00_1000_0000,
        S_RD_DATA = 10'b01_0000_0000,
        S_DONE    = 10'b10_0000_0000
    } t_state;

endpackage

// ===== hw/rtl/tcw_ram.sv =====
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/text_console_writer_unit.sv =====
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Text-mode console engine over a ROWS x COLS cell store: put, clear, read.
//
//  channel     | dir | handshake                         | payload
//  ------------+-----+-----------------------------------+------------------
//  s_axis      | in  | s_axis_tvalid / s_axis_tready     | cmd, char, addr
//  m_axis      | out | m_axis_tvalid / m_axis_tready     | cursor, read cell
//  cfg         | in  | i_cfg_valid / o_cfg_ready         | index, color
//
//  One item at a time: put a character or newline, read a cell, clear the
//  ROWS*COLS cells; an unused code only reports; a full screen scrolls
//  first. Every step is one access of the single-port-pair cell RAM; a
//  scroll copy reads a cell, then writes it one row up. Reset zeroes all CELLS
//  RAM cells before the first transfer. A stalled result holds in the output
//  register; the next item is taken meanwhile but finishes only once it drains.
// ----------------------------------------------------------------------------
module text_console_writer_unit #(
    parameter int ROWS  = 25,
    parameter int COLS  = 80,
    parameter int CELLS = 2000
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input items
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [7:0] char_code, [18:8] cell_addr, [23:19] zero
    input  logic [tcw_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // [1:0] cmd
    input  logic [tcw_pkg::CMD_W-1:0]           s_axis_tuser,
    // result items
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [10:0] cursor_pos, [15:11] cursor_row, [22:16] cursor_col,
    // [23] scrolled, [31:24] read_char, [35:32] read_fg, [39:36] read_bg
    output logic [tcw_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [tcw_pkg::COLOR_W-1:0]         i_cfg_data
);

    import tcw_pkg::*;

    `include "text_console_writer_unit_macros.svh"

    // Derived sizes
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS + 1);
    localparam int CW    = $clog2(COLS);
    localparam int NCLR  = ROWS * COLS;
    localparam int MAXN  = (NCLR > CELLS) ? NCLR : CELLS;
    localparam int CNTW  = $clog2(MAXN);

    localparam logic [CNTW-1:0] CNT_SCR_LAST  = CNTW'(COLS * (ROWS - 1) - 1);
    localparam logic [CNTW-1:0] CNT_FILL_LAST = CNTW'(COLS - 1);
    localparam logic [CNTW-1:0] CNT_CLR_LAST  = CNTW'(NCLR - 1);
    localparam logic [CNTW-1:0] CNT_INIT_LAST = CNTW'(CELLS - 1);

    localparam logic [AW-1:0] COLS_MOD  = AW'(COLS % CELLS);
    localparam logic [AW-1:0] FILL_BASE = AW'(((ROWS - 1) * COLS) % CELLS);
    localparam logic [AW-1:0] ADDR_LAST = AW'(CELLS - 1);
    localparam logic [AW:0]   CELLS_X   = (AW + 1)'(CELLS);
    localparam logic [RW-1:0] ROW_FULL  = RW'(ROWS);
    localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
    localparam logic [CW-1:0] COL_LAST  = CW'(COLS - 1);

    // Shared address step: +1 modulo CELLS
    function automatic logic [AW-1:0] inc_wrap(input logic [AW-1:0] a);
        logic [AW-1:0] res;
        if (a == ADDR_LAST) begin
            res = '0;
        end else begin
            res = a + 1'b1;
        end
        return res;
    endfunction

    // Sum of two residues, reduced modulo CELLS
    function automatic logic [AW-1:0] add_mod(input logic [AW-1:0] a,
                                              input logic [AW-1:0] b);
        logic [AW:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= CELLS_X) begin
            sum = sum - CELLS_X;
        end
        return sum[AW-1:0];
    endfunction

    // State
    t_state             r_state, n_state;
    logic [RW-1:0]      r_row, n_row;
    logic [CW-1:0]      r_col, n_col;
    logic [AW-1:0]      r_base, n_base;     // row*COLS mod CELLS
    logic [AW-1:0]      r_colm, n_colm;     // col mod CELLS
    logic [AW-1:0]      r_addr, n_addr;     // write pointer of sweeps
    logic [AW-1:0]      r_src, n_src;       // scroll source pointer
    logic [CNTW-1:0]    r_cnt, n_cnt;
    logic [CHAR_W-1:0]  r_ch, n_ch;
    logic [ADDR_W-1:0]  r_caddr, n_caddr;
    logic               r_scr, n_scr;
    t_cell              r_rd, n_rd;
    logic [COLOR_W-1:0] r_fg, r_bg;
    logic               r_out_valid, n_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data, n_out_data;

    // RAM ports
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    t_cell              ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [CELL_W-1:0]  ram_rdata;

    // Cursor views
    logic [AW-1:0]          lin;
    logic [AW+ADDR_W-1:0]   caddr_ext;
    logic                   caddr_ok;
    logic [AW+POS_W-1:0]    pos_ext;
    logic [RW+OROW_W-1:0]   row_ext;
    logic [CW+OCOL_W-1:0]   col_ext;
    logic                   in_xfer;

    assign lin       = add_mod(r_base, r_colm);
    assign caddr_ext = {{AW{1'b0}}, r_caddr};
    assign caddr_ok  = (caddr_ext < (AW + ADDR_W)'(CELLS));
    assign pos_ext   = {{POS_W{1'b0}}, lin};
    assign row_ext   = {{OROW_W{1'b0}}, r_row};
    assign col_ext   = {{OCOL_W{1'b0}}, r_col};

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Cell store
    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // RAM write and read selection
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = '{bg: r_bg, fg: r_fg, ch: CH_SPACE};
        ram_raddr = r_src;
        case (r_state)
            S_INIT: begin
                ram_we    = 1'b1;
                ram_wdata = '0;
            end
            S_SCR_WR: begin
                ram_we    = 1'b1;
                ram_wdata = t_cell'(ram_rdata);
            end
            S_FILL, S_CLR: begin
                ram_we    = 1'b1;
            end
            S_PUT: begin
                ram_we    = (r_ch != CH_NEWLINE);
                ram_waddr = lin;
                ram_wdata = '{bg: r_bg, fg: r_fg, ch: r_ch};
            end
            S_RD_REQ: begin
                ram_raddr = caddr_ext[AW-1:0];
            end
            default: begin
                ram_we    = 1'b0;
            end
        endcase
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_base      = r_base;
        n_colm      = r_colm;
        n_addr      = r_addr;
        n_src       = r_src;
        n_cnt       = r_cnt;
        n_ch        = r_ch;
        n_caddr     = r_caddr;
        n_scr       = r_scr;
        n_rd        = r_rd;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        // result drains independently of the sequencer
        if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_INIT: begin
                n_addr = inc_wrap(r_addr);
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == CNT_INIT_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_xfer) begin
                    n_ch    = s_axis_tdata[CHAR_W-1:0];
                    n_caddr = s_axis_tdata[CHAR_W+ADDR_W-1:CHAR_W];
                    n_scr   = 1'b0;
                    n_rd    = '0;
                    n_addr  = '0;
                    n_cnt   = '0;
                    case (s_axis_tuser)
                        CMD_PUT: begin
                            if (r_row >= ROW_FULL) begin
                                n_src   = COLS_MOD;
                                n_state = S_SCR_RD;
                            end else begin
                                n_state = S_PUT;
                            end
                        end
                        CMD_CLEAR: n_state = S_CLR;
                        CMD_READ:  n_state = S_RD_REQ;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            // scroll copy: read source cell, then write it one row up
            S_SCR_RD: begin
                n_state = S_SCR_WR;
            end
            S_SCR_WR: begin
                n_src = inc_wrap(r_src);
                n_addr = inc_wrap(r_addr);
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == CNT_SCR_LAST) begin
                    n_addr  = FILL_BASE;
                    n_cnt   = '0;
                    n_state = S_FILL;
                end else begin
                    n_state = S_SCR_RD;
                end
            end
            // blank the last row, then park the cursor on it
            S_FILL: begin
                n_addr = inc_wrap(r_addr);
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == CNT_FILL_LAST) begin
                    n_row   = ROW_LAST;
                    n_col   = '0;
                    n_base  = FILL_BASE;
                    n_colm  = '0;
                    n_scr   = 1'b1;
                    n_state = S_PUT;
                end
            end
            // character write or newline, with column wrap
            S_PUT: begin
                if (r_ch == CH_NEWLINE || r_col == COL_LAST) begin
                    n_row  = r_row + 1'b1;
                    n_col  = '0;
                    n_base = add_mod(r_base, COLS_MOD);
                    n_colm = '0;
                end else begin
                    n_col  = r_col + 1'b1;
                    n_colm = inc_wrap(r_colm);
                end
                n_state = S_DONE;
            end
            S_CLR: begin
                n_addr = inc_wrap(r_addr);
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == CNT_CLR_LAST) begin
                    n_state = S_DONE;
                end
            end
            S_RD_REQ: begin
                n_state = S_RD_DATA;
            end
            S_RD_DATA: begin
                n_rd    = caddr_ok ? t_cell'(ram_rdata) : '0;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {r_rd.bg, r_rd.fg, r_rd.ch, r_scr,
                                   col_ext[OCOL_W-1:0], row_ext[OROW_W-1:0],
                                   pos_ext[POS_W-1:0]};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_row       <= '0;
            r_col       <= '0;
            r_base      <= '0;
            r_colm      <= '0;
            r_addr      <= '0;
            r_src       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_base      <= n_base;
            r_colm      <= n_colm;
            r_addr      <= n_addr;
            r_src       <= n_src;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_ch       <= n_ch;
        r_caddr    <= n_caddr;
        r_scr      <= n_scr;
        r_rd       <= n_rd;
        r_out_data <= n_out_data;
    end

    // Color registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= FG_RESET;
            r_bg <= BG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_FG_COLOR: r_fg <= i_cfg_data;
                CFG_BG_COLOR: r_bg <= i_cfg_data;
                default: begin
                    r_fg <= r_fg;
                end
            endcase
        end
    end

    // Checks
    `TCW_ASSERT_IMP(a_row_bound, 1'b1, r_row <= ROW_FULL, "cursor row beyond ROWS")
    `TCW_ASSERT_IMP(a_col_bound, 1'b1, r_col <= COL_LAST, "cursor column beyond COLS-1")
    `TCW_ASSERT_IMP(a_ptr_bound, 1'b1, r_addr <= ADDR_LAST && r_src <= ADDR_LAST, "sweep pointer out of range")
    `TCW_ASSERT_IMP(a_quiet_idle, r_state == S_IDLE || r_state == S_DONE, !ram_we, "cell write outside a command")
    `TCW_ASSERT_NXT(a_fill_to_put, r_state == S_FILL && r_cnt == CNT_FILL_LAST, r_state == S_PUT && r_row == ROW_LAST && r_scr, "scroll did not hand over to put")

endmodule
